FILE: rtl/ovt_pkg.sv
// Shared types, constants and helpers for the open addressing value table.
package ovt_pkg;

    localparam int SLOT_ADDR_BITS = 10;
    localparam int VALUE_BITS     = 32;
    localparam int DEPTH          = 1 << SLOT_ADDR_BITS;

    // Field widths fixed by the interface
    localparam int HANDLE_BITS = 10;
    localparam int DATA_BITS   = 32;
    localparam int MULT_BITS   = 32;
    localparam int CMD_BITS    = 2;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    localparam logic [HANDLE_BITS-1:0] ADDR_LIMIT = HANDLE_BITS'(DEPTH - 1);

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_NEXT   = 2'd2;

    localparam logic [1:0] REG_SLOT_MASK = 2'd0;
    localparam logic [1:0] REG_HASH_MULT = 2'd1;
    localparam logic [1:0] REG_PROBE_STEP = 2'd2;

    localparam logic [HANDLE_BITS-1:0] SLOT_MASK_RST  = 10'd1023;
    localparam logic [MULT_BITS-1:0]   HASH_MULT_RST  = 32'd2654435761;
    localparam logic [HANDLE_BITS-1:0] PROBE_STEP_RST = 10'd1;

    typedef struct packed {
        logic [CMD_BITS-1:0]    cmd;
        logic [DATA_BITS-1:0]   key;
        logic [DATA_BITS-1:0]   entry_value;
        logic [HANDLE_BITS-1:0] slot_handle;
    } req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]   found_value;
        logic [HANDLE_BITS-1:0] handle_out;
        logic                   status;
    } rsp_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] slot_mask;
        logic [MULT_BITS-1:0]   hash_multiplier;
        logic [HANDLE_BITS-1:0] probe_step;
    } cfg_t;

    function automatic logic [HANDLE_BITS-1:0] advance(
        input logic [HANDLE_BITS-1:0] pos,
        input logic [HANDLE_BITS-1:0] step,
        input logic [HANDLE_BITS-1:0] mask
    );
        return (pos + step) & mask;
    endfunction

    function automatic logic [SLOT_ADDR_BITS-1:0] mem_addr(
        input logic [HANDLE_BITS-1:0] pos
    );
        return SLOT_ADDR_BITS'(pos);
    endfunction

endpackage

FILE: rtl/open_addressing_value_table.sv
// Top level of the open addressing value table with linear probing.
//
//  channel   handshake              payload   direction
//  command   start / busy           req       in
//  result    done (one-cycle pulse) rsp       out
//  config    psel/penable/pwrite    paddr...  in, APB-style
//
// Search and next pass from accept to done through hash/advance, memory
// read and check. Insert probes slots until one is empty or all are visited;
// one slot is read per cycle through the single read port of the slot memory.
// Unknown commands answer on the cycle after accept.
// After reset the memory is cleared one slot per cycle; busy
// stays high meanwhile. The receiver cannot stall: done lasts one cycle.
module open_addressing_value_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ovt_pkg::req_t                    req,
    output logic                             done,
    output ovt_pkg::rsp_t                    rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ovt_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [ovt_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [ovt_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready
);
    import ovt_pkg::*;

    typedef enum logic [1:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CHK
    } state_t;

    state_t                    state_reg;
    logic [SLOT_ADDR_BITS-1:0] clr_reg;
    logic [HANDLE_BITS-1:0]    pos_reg;
    logic [HANDLE_BITS-1:0]    home_reg;
    logic [HANDLE_BITS-1:0]    visits_reg;
    logic [CMD_BITS-1:0]       cmd_reg;
    logic [VALUE_BITS-1:0]     val_reg;
    logic                      done_reg;
    rsp_t                      rsp_reg;

    cfg_t                      cfg;
    logic [HANDLE_BITS-1:0]    eff_mask;
    logic [2*HANDLE_BITS-1:0]  prod;
    logic [HANDLE_BITS-1:0]    home_next;
    logic [HANDLE_BITS-1:0]    adv_pos;
    logic [HANDLE_BITS-1:0]    rd_pos;
    logic                      accept;
    logic                      slot_empty;
    logic                      ram_we;
    logic [SLOT_ADDR_BITS-1:0] ram_waddr;
    logic [VALUE_BITS-1:0]     ram_wdata;
    logic [VALUE_BITS-1:0]     ram_rdata;

    ovt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign eff_mask = cfg.slot_mask & ADDR_LIMIT;

    // Only the low product bits survive the mask, so a narrow multiply suffices
    assign prod      = req.key[HANDLE_BITS-1:0] * cfg.hash_multiplier[HANDLE_BITS-1:0];
    assign home_next = prod[HANDLE_BITS-1:0] & eff_mask;

    assign adv_pos    = advance(pos_reg, cfg.probe_step, eff_mask);
    // While probing, the next slot is read in the same cycle as the check
    assign rd_pos     = (state_reg == ST_CHK) ? adv_pos : pos_reg;
    assign accept     = start && !busy;
    assign slot_empty = (ram_rdata == '0);

    assign ram_we    = (state_reg == ST_CLR)
                    || (state_reg == ST_CHK && cmd_reg == CMD_INSERT && slot_empty);
    assign ram_waddr = (state_reg == ST_CLR) ? clr_reg : mem_addr(pos_reg);
    assign ram_wdata = (state_reg == ST_CLR) ? '0 : val_reg;

    ovt_slot_ram #(
        .ADDR_BITS (SLOT_ADDR_BITS),
        .WORD_BITS (VALUE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (mem_addr(rd_pos)),
        .rdata (ram_rdata)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            pos_reg    <= '0;
            home_reg   <= '0;
            visits_reg <= '0;
            cmd_reg    <= '0;
            val_reg    <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SLOT_ADDR_BITS'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= req.cmd;
                        val_reg    <= VALUE_BITS'(req.entry_value);
                        home_reg   <= home_next;
                        visits_reg <= '0;
                        case (req.cmd)
                            CMD_INSERT, CMD_SEARCH:
                            begin
                                pos_reg   <= home_next;
                                state_reg <= ST_RD;
                            end
                            CMD_NEXT:
                            begin
                                pos_reg   <= advance(req.slot_handle, cfg.probe_step,
                                                     eff_mask);
                                state_reg <= ST_RD;
                            end
                            default:
                            begin
                                rsp_reg  <= '0;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (cmd_reg != CMD_INSERT)
                    begin
                        rsp_reg.found_value <= DATA_BITS'(ram_rdata);
                        rsp_reg.handle_out  <= pos_reg;
                        rsp_reg.status      <= 1'b0;
                        done_reg            <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                    else if (slot_empty)
                    begin
                        rsp_reg.found_value <= DATA_BITS'(val_reg);
                        rsp_reg.handle_out  <= pos_reg;
                        rsp_reg.status      <= 1'b0;
                        done_reg            <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                    else if (visits_reg == eff_mask)
                    begin
                        // every reachable slot visited: table full
                        rsp_reg.found_value <= '0;
                        rsp_reg.handle_out  <= home_reg;
                        rsp_reg.status      <= 1'b1;
                        done_reg            <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg    <= adv_pos;
                        visits_reg <= visits_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_full_has_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status |-> rsp.found_value == '0)
        else $error("table-full result carries a value");

    a_write_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLR) || (state_reg == ST_CHK && slot_empty))
        else $error("slot written while not empty outside clearing");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy || done)
        else $error("accepted command neither in work nor answered");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |=> !done)
        else $error("result issued during clearing pass");

endmodule

FILE: rtl/ovt_slot_ram.sv
// Simple dual-port slot memory, one write and one registered read per cycle.
module ovt_slot_ram #(
    parameter int ADDR_BITS = 10,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [1 << ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ovt_cfg_regs.sv
// APB-style configuration registers of the value table.
module ovt_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ovt_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [ovt_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [ovt_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready,
    output ovt_pkg::cfg_t                    cfg
);
    import ovt_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_mask       <= SLOT_MASK_RST;
            cfg_reg.hash_multiplier <= HASH_MULT_RST;
            cfg_reg.probe_step      <= PROBE_STEP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SLOT_MASK:  cfg_reg.slot_mask       <= pwdata[HANDLE_BITS-1:0];
                REG_HASH_MULT:  cfg_reg.hash_multiplier <= pwdata[MULT_BITS-1:0];
                REG_PROBE_STEP: cfg_reg.probe_step      <= pwdata[HANDLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SLOT_MASK:  prdata = PDATA_BITS'(cfg_reg.slot_mask);
            REG_HASH_MULT:  prdata = PDATA_BITS'(cfg_reg.hash_multiplier);
            REG_PROBE_STEP: prdata = PDATA_BITS'(cfg_reg.probe_step);
            default:        prdata = '0;
        endcase
    end

endmodule
